FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define LSH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included
`define LSH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/core/lodsel_pkg.sv
// Types and constants for the level-of-detail selector
package lodsel_pkg;

  localparam int DistRegs  = 4;
  localparam int DistW     = 24;
  localparam int ViewDistW = 23;
  localparam int CountW    = 4;
  localparam int SysCntW   = 3;
  localparam int LevelW    = 2;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 24;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DIST_0   = 3'd0,
    CFG_DIST_1   = 3'd1,
    CFG_DIST_2   = 3'd2,
    CFG_DIST_3   = 3'd3,
    CFG_MARGIN   = 3'd4,
    CFG_SYS_CNT  = 3'd5
  } lod_cfg_idx_e;

  localparam logic [SysCntW-1:0] SysCntMax = SysCntW'(DistRegs);

  typedef struct packed {
    logic signed [DistRegs-1:0][DistW-1:0] lod_thr;
    logic signed [DistW-1:0]               margin;
    logic [SysCntW-1:0]                    sys_cnt;
  } lod_cfg_t;

  typedef struct packed {
    logic [ViewDistW-1:0] view_dist;
    logic [CountW-1:0]    emit_cnt;
    logic [CountW-1:0]    cur_level;
    logic                 tmpl_ok;
    logic                 cam_ok;
  } lod_item_t;

endpackage

FILE: rtl/core/lodsel_pick.sv
// Threshold scan and hysteresis decision for one query
module lodsel_pick #(
  parameter int MAX_LEVELS = 4
) (
  input  lodsel_pkg::lod_cfg_t         cfg_i,
  input  lodsel_pkg::lod_item_t        item_i,
  output logic [lodsel_pkg::LevelW-1:0] level_o
);
  import lodsel_pkg::*;

  localparam int Cap = (MAX_LEVELS < DistRegs) ? MAX_LEVELS : DistRegs;
  localparam logic [CountW-1:0] CapCnt = CountW'(Cap);
  localparam int CmpW = DistW + 1;

  logic [CountW-1:0]      cnt;
  logic [CountW-1:0]      cur_cl;
  logic [LevelW-1:0]      sel;
  logic [LevelW-1:0]      cur;
  logic [LevelW-1:0]      nxt;
  logic signed [CmpW-1:0] dist_s;
  logic signed [CmpW-1:0] margin_s;
  logic signed [CmpW-1:0] far_lim;
  logic signed [CmpW-1:0] near_lim;
  logic signed [CmpW-1:0] thr [DistRegs];
  logic signed [CmpW-1:0] prev;
  logic                   stop;
  logic                   skip;

  // element selects of the packed array are unsigned, so sign-extend explicitly
  always_comb begin
    for (int k = 0; k < DistRegs; k++) begin
      thr[k] = CmpW'(signed'(cfg_i.lod_thr[k]));
    end
  end

  assign dist_s = signed'(CmpW'(item_i.view_dist));

  // usable level count
  always_comb begin
    cnt = item_i.emit_cnt;
    if (CountW'(cfg_i.sys_cnt) < cnt) begin
      cnt = CountW'(cfg_i.sys_cnt);
    end
    if (cnt > CapCnt) begin
      cnt = CapCnt;
    end
  end

  assign skip = !item_i.tmpl_ok || !item_i.cam_ok || (item_i.emit_cnt <= CountW'(1)) ||
                (cnt <= CountW'(1));

  // scan ascending thresholds, stop on negative, descending or unreached
  always_comb begin
    sel  = '0;
    prev = thr[0];
    stop = 1'b0;
    for (int k = 1; k < DistRegs; k++) begin
      if (!stop && (CountW'(k) < cnt)) begin
        if (thr[k][CmpW-1] || (thr[k] < prev) || (dist_s < thr[k])) begin
          stop = 1'b1;
        end else begin
          sel  = LevelW'(k);
          prev = thr[k];
        end
      end
    end
  end

  assign cur_cl   = (item_i.cur_level > cnt - CountW'(1)) ? cnt - CountW'(1) : item_i.cur_level;
  assign cur      = cur_cl[LevelW-1:0];
  assign nxt      = cur + LevelW'(1);
  assign margin_s = cfg_i.margin[DistW-1] ? '0 : CmpW'(cfg_i.margin);
  assign far_lim  = thr[nxt] + margin_s;
  assign near_lim = thr[cur] - margin_s;

  always_comb begin
    if (skip) begin
      level_o = '0;
    end else if ((margin_s == '0) || (sel == cur)) begin
      level_o = sel;
    end else if (sel > cur) begin
      level_o = (dist_s < far_lim) ? cur : sel;
    end else begin
      // dist is never negative, so a negative limit always holds
      level_o = (dist_s >= near_lim) ? cur : sel;
    end
  end

endmodule

FILE: rtl/core/lod_select_with_hysteresis.sv
// Path: an input transaction is held in the input register, then in the result register.
// Throughput: one transaction per cycle while the output is not stalled; the threshold
// compare tree between the two registers is combinational.
// Input stalls only while both stages hold data and the output is stalled.
// Reset clears valid flags and all configuration registers to zero.
module lod_select_with_hysteresis #(
  parameter int MAX_LEVELS = 4
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [lodsel_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [lodsel_pkg::CfgDataW-1:0]        cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [lodsel_pkg::ViewDistW-1:0]       viewer_distance_i,
  input  logic [lodsel_pkg::CountW-1:0]          emitter_level_count_i,
  input  logic [lodsel_pkg::CountW-1:0]          current_level_i,
  input  logic                                   template_valid_i,
  input  logic                                   camera_valid_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [lodsel_pkg::LevelW-1:0]          selected_level_o
);
  import lodsel_pkg::*;

  lod_cfg_t          cfg_q;
  lod_item_t         item_q;
  logic              s1_valid_q;
  logic              s2_valid_q;
  logic [LevelW-1:0] level_d;
  logic [LevelW-1:0] level_q;
  logic              advance;
  logic              in_take;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (lod_cfg_idx_e'(cfg_idx_i))
        CFG_DIST_0:  cfg_q.lod_thr[0] <= cfg_wdata_i;
        CFG_DIST_1:  cfg_q.lod_thr[1] <= cfg_wdata_i;
        CFG_DIST_2:  cfg_q.lod_thr[2] <= cfg_wdata_i;
        CFG_DIST_3:  cfg_q.lod_thr[3] <= cfg_wdata_i;
        CFG_MARGIN:  cfg_q.margin     <= cfg_wdata_i;
        CFG_SYS_CNT: begin
          cfg_q.sys_cnt <= (cfg_wdata_i[SysCntW-1:0] > SysCntMax) ? SysCntMax
                                                                  : cfg_wdata_i[SysCntW-1:0];
        end
        default: ;
      endcase
    end
  end

  assign advance    = s1_valid_q && (!s2_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        s2_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.view_dist <= viewer_distance_i;
      item_q.emit_cnt  <= emitter_level_count_i;
      item_q.cur_level <= current_level_i;
      item_q.tmpl_ok   <= template_valid_i;
      item_q.cam_ok    <= camera_valid_i;
    end
    if (advance) begin
      level_q <= level_d;
    end
  end

  lodsel_pick #(
    .MAX_LEVELS(MAX_LEVELS)
  ) u_pick (
    .cfg_i   (cfg_q),
    .item_i  (item_q),
    .level_o (level_d)
  );

  assign out_valid_o      = s2_valid_q;
  assign selected_level_o = level_q;

endmodule

FILE: rtl/core/lodsel_chk.sv
// Port-level checker for the level-of-detail selector, bound to the top level
`include "assert_macros.svh"

module lodsel_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [lodsel_pkg::LevelW-1:0] selected_level_o
);

  // a stalled result stays put
  `LSH_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(selected_level_o)), "result changed while stalled")

  // back-pressure only comes from a full, stalled output
  `LSH_ASSERT(a_stall_src, in_stall_o |-> (out_valid_o && out_stall_i), "input stalled with output free")

  // a pending input transaction is never held off by an empty output stage
  `LSH_ASSERT(a_no_idle_stall, (in_valid_i && !out_valid_o) |-> !in_stall_o, "input stalled while output empty")

  // reset empties the output stage
  `LSH_ASSERT_ALWAYS(a_rst_clear, !rst_ni |=> !out_valid_o, "result valid right after reset")

endmodule

bind lod_select_with_hysteresis lodsel_chk u_lodsel_chk (.*);
